[hdl/fdm_pkg.sv]
// Shared types and constants for the frame-difference motion grid.
`default_nettype none
package fdm_pkg;

  // Configuration register map, one 32-bit word per register.
  localparam int CFG_AW = 5;
  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IW-1:0] REG_GRID_COLS    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_GRID_ROWS    = 3'd3;
  localparam logic [CFG_IW-1:0] REG_THRESHOLD    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_FLOOR        = 3'd5;

  localparam logic [10:0] RST_FRAME_WIDTH  = 11'd800;
  localparam logic [10:0] RST_FRAME_HEIGHT = 11'd600;
  localparam logic [4:0]  RST_GRID_COLS    = 5'd8;
  localparam logic [4:0]  RST_GRID_ROWS    = 5'd8;
  localparam logic [7:0]  RST_THRESHOLD    = 8'd16;
  localparam logic [16:0] RST_FLOOR        = 17'd6554;

  // Rec.601 luma weights in Q14, with rounding offset.
  localparam logic [13:0] GRAY_WB    = 14'd1868;
  localparam logic [13:0] GRAY_WG    = 14'd9617;
  localparam logic [13:0] GRAY_WR    = 14'd4899;
  localparam logic [21:0] GRAY_ROUND = 22'd8192;

  localparam logic [16:0] LEVEL_MAX = 17'd65536;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

[hdl/frame_diff_motion_grid_core.sv]
// Top level: frame store, per-cell counting and cell level output.
//
//  Channel | Ports                                   | Beat
//  --------+-----------------------------------------+-------------------------
//  in      | in_valid/in_stall, in_blue/green/red    | one BGR pixel, raster order
//  out     | out_valid/out_stall, out_cell_row/col,  | one finished grid cell
//          | out_level, out_frame_done               |
//  cfg     | cfg_psel/penable/pwrite/paddr/pwdata    | 32-bit register access
//
// In a frame a pixel is taken every cycle; its frame store read and write fall in the same
// cycle, and the per-cell count is updated in the cycle after, with forwarding.
// Each frame start stalls the input for the size division and the area multiply.
// A cell-completing pixel stalls while the level divider still holds the previous cell.
// After reset the block waits for the first pixel; no clear pass.
// out_stall only delays results; the divider then holds its quotient.
`default_nettype none
module frame_diff_motion_grid_core
  import fdm_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_GRID   = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_blue,
  input  wire logic [7:0]        in_green,
  input  wire logic [7:0]        in_red,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [3:0]             out_cell_row,
  output logic [3:0]             out_cell_col,
  output logic [16:0]            out_level,
  output logic                   out_frame_done,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int LIN_W = $clog2(MAX_HEIGHT);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int GRD_W = $clog2(MAX_GRID + 1);
  localparam int GIX_W = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LNUM_W = CNT_W + 16;

  // Configuration registers.
  logic [10:0] fw_r, fh_r;
  logic [4:0]  gc_r, gr_r;
  logic [7:0]  thr_r;
  logic [16:0] floor_r;
  logic        cfg_wr;
  logic [CFG_IW-1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r    <= RST_FRAME_WIDTH;
      fh_r    <= RST_FRAME_HEIGHT;
      gc_r    <= RST_GRID_COLS;
      gr_r    <= RST_GRID_ROWS;
      thr_r   <= RST_THRESHOLD;
      floor_r <= RST_FLOOR;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  fw_r    <= cfg_pwdata[10:0];
        REG_FRAME_HEIGHT: fh_r    <= cfg_pwdata[10:0];
        REG_GRID_COLS:    gc_r    <= cfg_pwdata[4:0];
        REG_GRID_ROWS:    gr_r    <= cfg_pwdata[4:0];
        REG_THRESHOLD:    thr_r   <= cfg_pwdata[7:0];
        REG_FLOOR:        floor_r <= cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  cfg_prdata = 32'(fw_r);
      REG_FRAME_HEIGHT: cfg_prdata = 32'(fh_r);
      REG_GRID_COLS:    cfg_prdata = 32'(gc_r);
      REG_GRID_ROWS:    cfg_prdata = 32'(gr_r);
      REG_THRESHOLD:    cfg_prdata = 32'(thr_r);
      REG_FLOOR:        cfg_prdata = 32'(floor_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // Clamped frame and grid sizes.
  logic [WID_W-1:0] w_cl;
  logic [HGT_W-1:0] h_cl;
  logic [GRD_W-1:0] c_cl, r_cl;

  always_comb begin
    if (fw_r == 11'd0)                w_cl = WID_W'(1);
    else if (32'(fw_r) > MAX_WIDTH)   w_cl = WID_W'(MAX_WIDTH);
    else                              w_cl = WID_W'(fw_r);
    if (fh_r == 11'd0)                h_cl = HGT_W'(1);
    else if (32'(fh_r) > MAX_HEIGHT)  h_cl = HGT_W'(MAX_HEIGHT);
    else                              h_cl = HGT_W'(fh_r);
    if (gc_r == 5'd0)                 c_cl = GRD_W'(1);
    else if (32'(gc_r) > MAX_GRID)    c_cl = GRD_W'(MAX_GRID);
    else                              c_cl = GRD_W'(gc_r);
    if (gr_r == 5'd0)                 r_cl = GRD_W'(1);
    else if (32'(gr_r) > MAX_GRID)    r_cl = GRD_W'(MAX_GRID);
    else                              r_cl = GRD_W'(gr_r);
  end

  // Frame-start sequencer: latch sizes, divide, multiply, run.
  typedef enum logic [1:0] {S_WAIT, S_DIV, S_MUL, S_RUN} state_t;
  state_t state_r;

  logic [WID_W-1:0] lat_w_r, cw_r;
  logic [HGT_W-1:0] lat_h_r, ch_r;
  logic [GRD_W-1:0] lat_cols_r, lat_rows_r;
  logic [CNT_W-1:0] area_r;

  div_stat_t        wstat, hstat, lstat;
  logic [WID_W-1:0] wquo;
  logic [HGT_W-1:0] hquo;
  logic             sdiv_start, sdiv_ack, frame_end, acc;

  assign sdiv_start = (state_r == S_WAIT) && in_valid && !cfg_wr;
  assign sdiv_ack   = (state_r == S_DIV) && wstat.done && hstat.done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WAIT;
    end else begin
      unique case (state_r)
        S_WAIT: begin
          if (sdiv_start) begin
            lat_w_r    <= w_cl;
            lat_h_r    <= h_cl;
            lat_cols_r <= c_cl;
            lat_rows_r <= r_cl;
            state_r    <= S_DIV;
          end
        end
        S_DIV: begin
          if (cfg_wr) begin
            state_r <= S_WAIT;
          end else if (sdiv_ack) begin
            cw_r    <= wquo;
            ch_r    <= hquo;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          area_r  <= CNT_W'(cw_r) * CNT_W'(ch_r);
          state_r <= cfg_wr ? S_WAIT : S_RUN;
        end
        S_RUN: begin
          if (acc && frame_end) begin
            state_r <= S_WAIT;
          end
        end
        default: state_r <= S_WAIT;
      endcase
    end
  end

  fdm_div #(.NUM_W(WID_W), .DEN_W(GRD_W)) u_wdiv (
    .clk, .rst_n, .start(sdiv_start), .ack(sdiv_ack),
    .num(w_cl), .den(c_cl), .stat(wstat), .quo(wquo)
  );

  fdm_div #(.NUM_W(HGT_W), .DEN_W(GRD_W)) u_hdiv (
    .clk, .rst_n, .start(sdiv_start), .ack(sdiv_ack),
    .num(h_cl), .den(r_cl), .stat(hstat), .quo(hquo)
  );

  // Position counters, including offsets inside the current cell.
  logic [COL_W-1:0] col_r, cx_r;
  logic [LIN_W-1:0] line_r, cy_r;
  logic [GRD_W-1:0] ccol_r, crow_r;
  logic             have_prev_r;

  logic             a_cell, a_last, a_fd, col_wrap, cx_end, cy_end;
  logic [GIX_W-1:0] a_idx;
  logic [ADR_W-1:0] a_addr;

  logic             b_valid_r, b_cell_r, b_last_r, b_fd_r, b_vbit_r, b_fwd_r;
  logic [GIX_W-1:0] b_idx_r;
  logic [GRD_W-1:0] b_crow_r, b_ccol_r;
  logic [23:0]      b_pix_r;
  logic [CNT_W-1:0] b_fwd_val_r;

  always_comb begin
    a_cell = have_prev_r && (cw_r != '0) && (ch_r != '0) &&
             (ccol_r < lat_cols_r) && (crow_r < lat_rows_r);
    cx_end = (WID_W'(cx_r) == cw_r - WID_W'(1));
    cy_end = (HGT_W'(cy_r) == ch_r - HGT_W'(1));
    a_last = a_cell && cx_end && cy_end;
    a_fd   = (crow_r == lat_rows_r - GRD_W'(1)) && (ccol_r == lat_cols_r - GRD_W'(1));
    a_idx  = ccol_r[GIX_W-1:0];
    a_addr = ADR_W'(line_r) * ADR_W'(MAX_WIDTH) + ADR_W'(col_r);
    col_wrap  = (WID_W'(col_r) + WID_W'(1) >= lat_w_r);
    frame_end = col_wrap && (HGT_W'(line_r) + HGT_W'(1) >= lat_h_r);
  end

  // A cell-completing pixel waits until the level divider can take it.
  assign in_stall = (state_r != S_RUN) ||
                    (a_last && (lstat.busy || lstat.done || (b_valid_r && b_last_r)));
  assign acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      line_r      <= '0;
      cx_r        <= '0;
      cy_r        <= '0;
      ccol_r      <= '0;
      crow_r      <= '0;
      have_prev_r <= 1'b0;
    end else if (acc) begin
      if (col_wrap) begin
        col_r  <= '0;
        cx_r   <= '0;
        ccol_r <= '0;
        if (frame_end) begin
          line_r      <= '0;
          cy_r        <= '0;
          crow_r      <= '0;
          have_prev_r <= 1'b1;
        end else begin
          line_r <= line_r + LIN_W'(1);
          if (cy_end) begin
            cy_r <= '0;
            if (crow_r != lat_rows_r) crow_r <= crow_r + GRD_W'(1);
          end else begin
            cy_r <= cy_r + LIN_W'(1);
          end
        end
      end else begin
        col_r <= col_r + COL_W'(1);
        if (cx_end) begin
          cx_r <= '0;
          if (ccol_r != lat_cols_r) ccol_r <= ccol_r + GRD_W'(1);
        end else begin
          cx_r <= cx_r + COL_W'(1);
        end
      end
    end
  end

  // Frame store: previous pixel read and new pixel written in the same cycle.
  logic [23:0] prev_pix;

  fdm_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_frame (
    .clk, .we(acc), .waddr(a_addr), .wdata({in_red, in_green, in_blue}),
    .raddr(a_addr), .rdata(prev_pix)
  );

  // Per-column cell counts for the current cell row.
  logic                cnt_we;
  logic [CNT_W-1:0]    cnt_rdata, cnt_wdata, cnt_old, cnt_new;
  logic [MAX_GRID-1:0] cvalid_r;

  fdm_ram #(.WIDTH(CNT_W), .DEPTH(MAX_GRID)) u_count (
    .clk, .we(cnt_we), .waddr(b_idx_r), .wdata(cnt_wdata),
    .raddr(a_idx), .rdata(cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_pix_r     <= {in_red, in_green, in_blue};
      b_cell_r    <= a_cell;
      b_last_r    <= a_last;
      b_fd_r      <= a_fd;
      b_idx_r     <= a_idx;
      b_crow_r    <= crow_r;
      b_ccol_r    <= ccol_r;
      b_vbit_r    <= cvalid_r[a_idx];
      b_fwd_r     <= cnt_we && (a_idx == b_idx_r);
      b_fwd_val_r <= cnt_wdata;
    end
  end

  // Gray of the absolute per-channel difference.
  logic [7:0]  db, dg, dr, gray;
  logic [21:0] gsum;
  logic        moving;

  always_comb begin
    db = (b_pix_r[7:0] >= prev_pix[7:0]) ? b_pix_r[7:0] - prev_pix[7:0]
                                         : prev_pix[7:0] - b_pix_r[7:0];
    dg = (b_pix_r[15:8] >= prev_pix[15:8]) ? b_pix_r[15:8] - prev_pix[15:8]
                                           : prev_pix[15:8] - b_pix_r[15:8];
    dr = (b_pix_r[23:16] >= prev_pix[23:16]) ? b_pix_r[23:16] - prev_pix[23:16]
                                             : prev_pix[23:16] - b_pix_r[23:16];
    gsum = 22'(GRAY_WB) * 22'(db) + 22'(GRAY_WG) * 22'(dg) +
           22'(GRAY_WR) * 22'(dr) + GRAY_ROUND;
    gray    = gsum[21:14];
    moving  = (gray > thr_r);
    cnt_old = b_fwd_r ? b_fwd_val_r : (b_vbit_r ? cnt_rdata : '0);
    cnt_new = cnt_old + CNT_W'(moving);
    cnt_we    = b_valid_r && b_cell_r;
    cnt_wdata = b_last_r ? '0 : cnt_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvalid_r <= '0;
    end else if (state_r == S_MUL) begin
      cvalid_r <= '0;
    end else if (cnt_we) begin
      cvalid_r[b_idx_r] <= 1'b1;
    end
  end

  // Level division and result register.
  logic              ldiv_start, ldiv_ack, out_load;
  logic [LNUM_W-1:0] lquo;
  logic [16:0]       lvl;
  logic [GRD_W-1:0]  j_row_r, j_col_r;
  logic              j_fd_r;

  assign ldiv_start = b_valid_r && b_last_r;

  fdm_div #(.NUM_W(LNUM_W), .DEN_W(CNT_W)) u_ldiv (
    .clk, .rst_n, .start(ldiv_start), .ack(ldiv_ack),
    .num({cnt_new, 16'd0}), .den(area_r), .stat(lstat), .quo(lquo)
  );

  always_ff @(posedge clk) begin
    if (ldiv_start) begin
      j_row_r <= b_crow_r;
      j_col_r <= b_ccol_r;
      j_fd_r  <= b_fd_r;
    end
  end

  always_comb begin
    lvl = (lquo > LNUM_W'(LEVEL_MAX)) ? LEVEL_MAX : lquo[16:0];
    if (lvl < floor_r) lvl = '0;
  end

  assign out_load = lstat.done && (!out_valid || !out_stall);
  assign ldiv_ack = out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cell_row   <= 4'(j_row_r);
      out_cell_col   <= 4'(j_col_r);
      out_level      <= lvl;
      out_frame_done <= j_fd_r;
    end
  end

endmodule
`default_nettype wire

[hdl/fdm_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
`default_nettype none
module fdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when both ports hit one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/fdm_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module fdm_div
  import fdm_pkg::*;
#(
  parameter int NUM_W = 16,
  parameter int DEN_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             ack,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output div_stat_t             stat,
  output logic [NUM_W-1:0]      quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             run_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt, den_r;
  logic [DEN_W:0]   sh, diff;
  logic             ge;

  always_comb begin
    sh      = {rem_r, q_r[NUM_W-1]};
    diff    = sh - {1'b0, den_r};
    ge      = (sh >= {1'b0, den_r});
    rem_nxt = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
    q_nxt   = {q_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (run_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else if (ack) begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (run_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = run_r;
  assign stat.done = done_r;
  assign quo       = q_r;

endmodule
`default_nettype wire

[hdl/fdm_chk.sv]
// Port-level checker for the motion grid core, bound to the top level.
`default_nettype none
module fdm_chk
  import fdm_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [3:0]        out_cell_row,
  input wire logic [3:0]        out_cell_col,
  input wire logic [16:0]       out_level,
  input wire logic              out_frame_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_level) &&
      $stable(out_cell_row) && $stable(out_cell_col) && $stable(out_frame_done))
    else $error("result changed while stalled");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level <= LEVEL_MAX)
    else $error("cell level above one");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_rst_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("pixel taken before frame sizes are set up");

endmodule

bind frame_diff_motion_grid_core fdm_chk u_chk (.*);
`default_nettype wire

[sim/tb_frame_diff_motion_grid_core.sv]
// Self-checking testbench for the frame-difference motion grid core.
`default_nettype none
module tb_frame_diff_motion_grid_core;
  import fdm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_W      = 1024;
  localparam int FILL_W       = 40;
  localparam int STORE_H_MAX  = 12;
  localparam int GRID_MAX     = 16;
  localparam int SETTLE_CYC   = 80;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYC     = 300;
  localparam int ITEM_TARGET  = 1500;
  localparam int QUIET_FROM   = 1250;

  typedef struct packed {
    logic [3:0]  row;
    logic [3:0]  col;
    logic [16:0] level;
    logic        done;
  } cell_result_t;

  typedef struct packed {
    logic [7:0]   b;
    logic [7:0]   g;
    logic [7:0]   r;
    logic         typed;
    cell_result_t res;
  } pixel_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_blue = '0, in_green = '0, in_red = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [3:0]        out_cell_row, out_cell_col;
  logic [16:0]       out_level;
  logic              out_frame_done;
  logic              cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  frame_diff_motion_grid_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Register copies held by the predictor.
  int unsigned reg_w = RST_FRAME_WIDTH, reg_h = RST_FRAME_HEIGHT;
  int unsigned reg_gc = RST_GRID_COLS, reg_gr = RST_GRID_ROWS;
  int unsigned reg_thr = RST_THRESHOLD, reg_floor = RST_FLOOR;

  // Predictor state.
  logic [23:0] pixel_store [int];
  bit          have_prev = 1'b0;
  int unsigned col_cnt = 0, line_cnt = 0;
  int unsigned lat_w = 1, lat_h = 1, lat_cols = 1, lat_rows = 1;
  int unsigned cell_w = 0, cell_h = 0;
  int unsigned moving_cnt [GRID_MAX];

  cell_result_t cell_q[$];
  int errors = 0, items_sent = 0, cells_seen = 0, cells_expected = 0, phases = 0;
  bit quiet = 1'b0, tx_calm = 1'b0, rx_calm = 1'b0, hold_req = 1'b0;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned abs_diff(int unsigned a, int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit predict_cell(input logic [7:0] b, g, r, output cell_result_t res);
    int unsigned addr, cc, cr, gray;
    logic [23:0] prev;
    longint unsigned area, lvl;
    bit got;
    got = 1'b0;
    res = '0;
    if (col_cnt == 0 && line_cnt == 0) begin
      lat_w = clamp_size(reg_w, 1024);
      lat_h = clamp_size(reg_h, 1024);
      lat_cols = clamp_size(reg_gc, GRID_MAX);
      lat_rows = clamp_size(reg_gr, GRID_MAX);
      cell_w = lat_w / lat_cols;
      cell_h = lat_h / lat_rows;
      foreach (moving_cnt[i]) moving_cnt[i] = 0;
    end
    addr = line_cnt * STORE_W + col_cnt;
    prev = pixel_store.exists(addr) ? pixel_store[addr] : 24'd0;
    pixel_store[addr] = {r, g, b};
    if (have_prev && cell_w > 0 && cell_h > 0) begin
      cc = col_cnt / cell_w;
      cr = line_cnt / cell_h;
      if (cc < lat_cols && cr < lat_rows) begin
        gray = (1868 * abs_diff(b, prev[7:0]) + 9617 * abs_diff(g, prev[15:8])
                + 4899 * abs_diff(r, prev[23:16]) + 8192) >> 14;
        if (gray > reg_thr) moving_cnt[cc]++;
        if (col_cnt == (cc + 1) * cell_w - 1 && line_cnt == (cr + 1) * cell_h - 1) begin
          area = longint'(cell_w) * cell_h;
          lvl = (longint'(moving_cnt[cc]) << 16) / area;
          if (lvl > 65536) lvl = 65536;
          if (lvl < reg_floor) lvl = 0;
          res.row = cr[3:0];
          res.col = cc[3:0];
          res.level = lvl[16:0];
          res.done = (cr == lat_rows - 1 && cc == lat_cols - 1);
          moving_cnt[cc] = 0;
          got = 1'b1;
        end
      end
    end
    col_cnt++;
    if (col_cnt >= lat_w) begin
      col_cnt = 0;
      line_cnt++;
      if (line_cnt >= lat_h) begin
        line_cnt = 0;
        have_prev = 1'b1;
      end
    end
    return got;
  endfunction

  // Write a register, then read it back.
  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input int unsigned val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== val) begin
      errors++;
      if (errors <= 10)
        $display("register %0d readback: expected %0d, got %0d", idx, val, cfg_prdata);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  reg_w = val;
      REG_FRAME_HEIGHT: reg_h = val;
      REG_GRID_COLS:    reg_gc = val;
      REG_GRID_ROWS:    reg_gr = val;
      REG_THRESHOLD:    reg_thr = val;
      REG_FLOOR:        reg_floor = val;
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned w, h, gc, gr, thr, fl);
    cfg_write(REG_FRAME_WIDTH, w);
    cfg_write(REG_FRAME_HEIGHT, h);
    cfg_write(REG_GRID_COLS, gc);
    cfg_write(REG_GRID_ROWS, gr);
    cfg_write(REG_THRESHOLD, thr);
    cfg_write(REG_FLOOR, fl);
    phases++;
  endtask

  // Drain all pending cells, then give the level divider time to finish.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cell_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [7:0] b, g, r, input bit typed,
                            input cell_result_t typed_res);
    cell_result_t res;
    bit got;
    if (!quiet && !tx_calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_blue <= b;
    in_green <= g;
    in_red <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = predict_cell(b, g, r, res);
    if (got) begin
      cells_expected++;
      cell_q = {cell_q, (typed ? typed_res : res)};
    end
    items_sent++;
    if ($urandom_range(0, 199) == 0) tx_calm = !tx_calm;
  endtask

  // Sends one frame; content is random, close to the stored frame, or a copy of it.
  task automatic send_frame();
    int unsigned n, mode, addr, spread;
    logic [23:0] prev, px;
    mode = $urandom_range(0, 5);
    spread = $urandom_range(1, 80);
    n = clamp_size(reg_w, 1024) * clamp_size(reg_h, 1024);
    for (int unsigned k = 0; k < n; k++) begin
      addr = line_cnt * STORE_W + col_cnt;
      prev = pixel_store.exists(addr) ? pixel_store[addr] : 24'd0;
      px = $urandom;
      if (mode == 1 || mode == 2) px = prev;
      else if (mode >= 3)
        for (int c = 0; c < 3; c++)
          px[c*8 +: 8] = 8'(int'(prev[c*8 +: 8]) + $urandom_range(0, 2 * spread) - spread);
      send_pixel(px[7:0], px[15:8], px[23:16], 1'b0, '0);
    end
  endtask

  // Directed frames of 4x2 pixels, two cells of 2x2 side by side.
  pixel_row_t directed [24] = '{
    '{8'd255, 8'd255, 8'd255, 1'b0, '0},
    '{8'd0,   8'd0,   8'd0,   1'b0, '0},
    '{8'd255, 8'd0,   8'd0,   1'b0, '0},
    '{8'd0,   8'd0,   8'd255, 1'b0, '0},
    '{8'd0,   8'd255, 8'd0,   1'b0, '0},
    '{8'd0,   8'd0,   8'd0,   1'b1, '{4'd0, 4'd0, 17'd32768, 1'b0}},
    '{8'd1,   8'd0,   8'd0,   1'b0, '0},
    '{8'd0,   8'd0,   8'd0,   1'b1, '{4'd0, 4'd1, 17'd32768, 1'b1}},
    '{8'd255, 8'd255, 8'd255, 1'b0, '0},
    '{8'd0,   8'd0,   8'd0,   1'b0, '0},
    '{8'd10,  8'd200, 8'd30,  1'b0, '0},
    '{8'd0,   8'd0,   8'd0,   1'b0, '0},
    '{8'd7,   8'd7,   8'd7,   1'b0, '0},
    '{8'd255, 8'd255, 8'd255, 1'b0, '0},
    '{8'd1,   8'd2,   8'd3,   1'b0, '0},
    '{8'd200, 8'd100, 8'd50,  1'b0, '0},
    '{8'd0,   8'd0,   8'd0,   1'b0, '0},
    '{8'd255, 8'd255, 8'd255, 1'b0, '0},
    '{8'd0,   8'd255, 8'd0,   1'b0, '0},
    '{8'd255, 8'd0,   8'd255, 1'b0, '0},
    '{8'd255, 8'd0,   8'd0,   1'b0, '0},
    '{8'd0,   8'd0,   8'd0,   1'b1, '{4'd0, 4'd0, 17'd0, 1'b0}},
    '{8'd128, 8'd128, 8'd128, 1'b0, '0},
    '{8'd0,   8'd0,   8'd0,   1'b1, '{4'd0, 4'd1, 17'd0, 1'b1}}
  };

  initial begin
    logic [23:0] px;
    int unsigned w, h, gc, gr, thr, fl;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first frame only fills the store; it covers every position used later.
    configure(FILL_W, STORE_H_MAX, GRID_MAX, GRID_MAX, RST_THRESHOLD, RST_FLOOR);
    for (int ln = 0; ln < STORE_H_MAX; ln++)
      for (int c = 0; c < FILL_W; c++) begin
        px = (ln < 2 && c < 4) ? 24'd0 : 24'($urandom);
        send_pixel(px[7:0], px[15:8], px[23:16], 1'b0, '0);
      end
    wait_drained();

    configure(4, 2, 2, 1, 0, 0);
    foreach (directed[i]) begin
      if (i == 16) begin
        wait_drained();
        cfg_write(REG_THRESHOLD, 255);
        cfg_write(REG_FLOOR, LEVEL_MAX);
      end
      send_pixel(directed[i].b, directed[i].g, directed[i].r, directed[i].typed,
                 directed[i].res);
    end
    wait_drained();

    // Many small cells, with the receiver holding off so the input backs up.
    configure(32, 8, 16, 8, 20, 0);
    hold_req = 1'b1;
    repeat (2) send_frame();
    wait_drained();

    // Zero height and row count, and a column count above the maximum.
    configure(FILL_W, 0, 31, 0, 0, 0);
    send_frame();
    wait_drained();

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= QUIET_FROM) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0: begin w = $urandom_range(0, 1); h = $urandom_range(0, STORE_H_MAX); end
        1: begin w = $urandom_range(2, FILL_W); h = $urandom_range(0, 1); end
        default: begin w = $urandom_range(2, FILL_W); h = $urandom_range(2, STORE_H_MAX); end
      endcase
      gc = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
      gr = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
      thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 60);
      case ($urandom_range(0, 3))
        0: fl = 0;
        1: fl = LEVEL_MAX;
        default: fl = $urandom_range(0, 40000);
      endcase
      configure(w, h, gc, gr, thr, fl);
      repeat ($urandom_range(1, 3)) send_frame();
      wait_drained();
    end

    if (cell_q.size() != 0) begin
      errors += cell_q.size();
      $display("%0d expected cells never came out", cell_q.size());
    end
    $display("Covered %0d pixels over %0d settings; %0d cells checked of %0d expected.",
             items_sent, phases, cells_seen, cells_expected);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Result checking and receiver stalls.
  int unsigned stall_left = 0, hold_left = 0;
  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      cells_seen++;
      if (cell_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected cell r%0d c%0d level %0d done %0d",
                   out_cell_row, out_cell_col, out_level, out_frame_done);
      end else begin
        want = cell_q.pop_front();
        if (out_cell_row !== want.row || out_cell_col !== want.col ||
            out_level !== want.level || out_frame_done !== want.done) begin
          errors++;
          if (errors <= 10)
            $display("cell mismatch: want r%0d c%0d lvl %0d fd %0d, got r%0d c%0d lvl %0d fd %0d",
                     want.row, want.col, want.level, want.done,
                     out_cell_row, out_cell_col, out_level, out_frame_done);
        end
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYC;
    end
    if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && !rx_calm && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles without any accepted beat or register access.
  int unsigned dead_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel || !rst_n)
      dead_cycles <= 0;
    else if (dead_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d cells pending", cell_q.size());
      $display("DONE: errors detected");
      $finish;
    end else
      dead_cycles <= dead_cycles + 1;
  end

endmodule
`default_nettype wire
